>>> rtl/cfso_pkg.sv
// shared types and constants of the coupled-form sine oscillator
`default_nettype none

package cfso_pkg;

   typedef logic [1:0] command_type;
   typedef logic [1:0] csr_index_type;

   localparam command_type CMD_ADD     = 2'd0;
   localparam command_type CMD_REPLACE = 2'd1;
   localparam command_type CMD_BYPASS  = 2'd2;
   localparam command_type CMD_RESTART = 2'd3;

   localparam csr_index_type CSR_STEP_COEFFICIENT = 2'd0;
   localparam csr_index_type CSR_START_QUADRATURE = 2'd1;
   localparam csr_index_type CSR_START_INPHASE    = 2'd2;

   // configuration word width, coefficient width and its fraction bits
   localparam int CFG_BITS  = 32;
   localparam int EPS_BITS  = 32;
   localparam int EPS_FRAC  = 30;
   // fraction bits of the start values
   localparam int CFG_FRAC  = 29;

   // -1.0 in Q2.29
   localparam logic [CFG_BITS-1:0] START_QUAD_RESET = 32'hE000_0000;

endpackage

`default_nettype wire

>>> rtl/cfso_req_if.sv
// request channel: command and input sample
`default_nettype none

interface cfso_req_if #(
   parameter int SAMPLE_BITS = 24
);
   import cfso_pkg::*;

   logic                          valid;
   logic                          ready;
   command_type                   command;
   logic signed [SAMPLE_BITS-1:0] sample_in;

   modport source (output valid, output command, output sample_in, input ready);
   modport sink   (input valid, input command, input sample_in, output ready);

endinterface

`default_nettype wire

>>> rtl/cfso_rsp_if.sv
// response channel: output sample and clip flag
`default_nettype none

interface cfso_rsp_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   logic                          clipped;

   modport source (output valid, output sample_out, output clipped, input ready);
   modport sink   (input valid, input sample_out, input clipped, output ready);

endinterface

`default_nettype wire

>>> rtl/cfso_serial_mult.sv
// bit-serial coefficient multiplier, product rounded to the state scale
`default_nettype none

module cfso_serial_mult #(
   parameter int STATE_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [cfso_pkg::EPS_BITS-1:0]         coef,
   input  logic signed [STATE_BITS-1:0]          operand,
   output logic                                  done,
   output logic signed [STATE_BITS+cfso_pkg::EPS_BITS-cfso_pkg::EPS_FRAC:0] product
);
   import cfso_pkg::*;

   localparam int PW = STATE_BITS + 1 + EPS_BITS - EPS_FRAC;
   localparam int CW = $clog2(EPS_BITS + 1);

   logic [EPS_BITS-1:0]          eps_ff, eps_in;
   logic signed [STATE_BITS-1:0] x_ff;
   logic signed [STATE_BITS:0]   acc_ff, acc_in;
   logic [EPS_BITS-1:0]          low_ff, low_in;
   logic [CW-1:0]                cnt_ff;
   logic                         fin_ff;
   logic                         done_ff;
   logic signed [PW-1:0]         product_ff, product_in;

   logic signed [STATE_BITS+1:0] addend, sum;
   logic [EPS_BITS:0]            low_rnd;

   // one coefficient bit per cycle, lsb first
   always_comb begin
      addend  = eps_ff[0] ? {x_ff[STATE_BITS-1], x_ff[STATE_BITS-1], x_ff} : '0;
      sum     = {acc_ff[STATE_BITS], acc_ff} + addend;
      acc_in  = sum[STATE_BITS+1:1];
      low_in  = {sum[0], low_ff[EPS_BITS-1:1]};
      eps_in  = eps_ff >> 1;
      // round half up at the coefficient fraction
      low_rnd = {1'b0, low_ff} + ((EPS_BITS+1)'(1) << (EPS_FRAC - 1));
      product_in = $signed({acc_ff, {(EPS_BITS-EPS_FRAC){1'b0}}})
                 + $signed(PW'(low_rnd[EPS_BITS:EPS_FRAC]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= fin_ff;
         fin_ff  <= (cnt_ff == CW'(1));
         if (start) begin
            cnt_ff <= CW'(EPS_BITS);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         eps_ff <= coef;
         x_ff   <= operand;
         acc_ff <= '0;
      end else if (cnt_ff != '0) begin
         eps_ff <= eps_in;
         acc_ff <= acc_in;
         low_ff <= low_in;
      end
      if (fin_ff) begin
         product_ff <= product_in;
      end
   end

   assign done    = done_ff;
   assign product = product_ff;

endmodule

`default_nettype wire

>>> rtl/cfso_sample_out.sv
// result register: oscillator sample, mix with input, saturation
`default_nettype none

module cfso_sample_out #(
   parameter int SAMPLE_BITS = 24,
   parameter int STATE_BITS  = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  cfso_pkg::command_type         command,
   input  logic signed [SAMPLE_BITS-1:0] sample_in,
   input  logic signed [STATE_BITS-1:0]  inphase,
   output logic                          slot_free,
   cfso_rsp_if.source                    rsp_bus
);
   import cfso_pkg::*;

   // fraction bits dropped going from Q2.(STATE_BITS-3) to Q0.(SAMPLE_BITS-1)
   localparam int OSC_D   = (STATE_BITS - 3) - (SAMPLE_BITS - 1);
   localparam int AW      = ((STATE_BITS > SAMPLE_BITS) ? STATE_BITS : SAMPLE_BITS) + 4;
   localparam int SHR     = (OSC_D > 0) ? OSC_D : 0;
   localparam int SHL     = (OSC_D < 0) ? -OSC_D : 0;
   localparam int RND_POS = (SHR > 0) ? SHR - 1 : 0;
   localparam logic signed [AW-1:0] RND  = (SHR > 0) ? (AW'(1) << RND_POS) : '0;
   localparam logic signed [AW-1:0] SMAX =
      $signed({{(AW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
   localparam logic signed [AW-1:0] SMIN = ~SMAX;

   logic                          valid_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in_d;
   logic                          clipped_ff, clipped_in;

   logic signed [AW-1:0] osc, mix;

   always_comb begin
      osc = ((AW'(inphase) + RND) >>> SHR) <<< SHL;
      mix = osc;
      if (command == CMD_ADD) begin
         mix = osc + AW'(sample_in);
      end
      sample_in_d = mix[SAMPLE_BITS-1:0];
      clipped_in  = 1'b0;
      if (mix > SMAX) begin
         sample_in_d = SMAX[SAMPLE_BITS-1:0];
         clipped_in  = 1'b1;
      end else if (mix < SMIN) begin
         sample_in_d = SMIN[SAMPLE_BITS-1:0];
         clipped_in  = 1'b1;
      end
      if (command == CMD_BYPASS) begin
         sample_in_d = '0;
         clipped_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sample_ff  <= sample_in_d;
         clipped_ff <= clipped_in;
      end
   end

   assign slot_free          = !valid_ff || rsp_bus.ready;
   assign rsp_bus.valid      = valid_ff;
   assign rsp_bus.sample_out = sample_ff;
   assign rsp_bus.clipped    = clipped_ff;

endmodule

`default_nettype wire

>>> rtl/coupled_form_sine_oscillator_core.sv
// top level of the coupled-form sine oscillator
//
// channel  | direction | handshake     | payload
// req_bus  | in        | valid / ready | command, sample_in
// rsp_bus  | out       | valid / ready | sample_out, clipped
// csr_*    | in        | write enable  | csr_index, csr_write_data
//
// a sample item is answered in the cycle after it is taken; the state update
// then runs two bit-serial multiplies on the shared multiplier, and the next
// item is taken only once both are done
// a restart item loads the start values and gives no result
// reset loads quadrature -1.0 and in-phase 0; a stalled result holds in the
// output register and blocks the next item only while it is still unread
`default_nettype none

module coupled_form_sine_oscillator_core #(
   parameter int SAMPLE_BITS = 24,
   parameter int STATE_BITS  = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  cfso_pkg::csr_index_type         csr_index,
   input  logic [cfso_pkg::CFG_BITS-1:0]   csr_write_data,
   cfso_req_if.sink                        req_bus,
   cfso_rsp_if.source                      rsp_bus
);
   import cfso_pkg::*;

   // product width from the multiplier, update sum width
   localparam int PW = STATE_BITS + 1 + EPS_BITS - EPS_FRAC;
   localparam int SW = PW + 1;
   // restart load: rescale Q2.29 to the state format
   localparam int LW = (STATE_BITS + 1 > CFG_BITS + 1) ? STATE_BITS + 1 : CFG_BITS + 1;
   localparam int XW = (LW > SW) ? LW : SW;
   localparam int STATE_FRAC = STATE_BITS - 3;
   localparam int LOAD_SHR = (CFG_FRAC > STATE_FRAC) ? CFG_FRAC - STATE_FRAC : 0;
   localparam int LOAD_SHL = (STATE_FRAC > CFG_FRAC) ? STATE_FRAC - CFG_FRAC : 0;
   localparam int LRND_POS = (LOAD_SHR > 0) ? LOAD_SHR - 1 : 0;
   localparam logic signed [LW-1:0] LOAD_RND = (LOAD_SHR > 0) ? (LW'(1) << LRND_POS) : '0;
   localparam logic signed [XW-1:0] STMAX =
      $signed({{(XW-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}});
   localparam logic signed [XW-1:0] STMIN = ~STMAX;
   // -1.0 in the state format
   localparam logic [STATE_BITS-1:0] QUAD_RESET = {3'b111, {(STATE_BITS-3){1'b0}}};

   // sequencer codes
   localparam logic [1:0] ST_IDLE     = 2'd0;
   localparam logic [1:0] ST_MUL_QUAD = 2'd1;
   localparam logic [1:0] ST_MUL_INPH = 2'd2;

   logic [1:0]                   state_ff, state_in;
   logic [EPS_BITS-1:0]          step_ff;
   logic signed [CFG_BITS-1:0]   start_quad_ff, start_inph_ff;
   logic signed [STATE_BITS-1:0] quad_ff, quad_in;
   logic signed [STATE_BITS-1:0] inph_ff, inph_in;

   logic                         accept, restart, sample_go, slot_free;
   logic                         mult_start, mult_done;
   logic signed [STATE_BITS-1:0] mult_operand;
   logic signed [PW-1:0]         product;
   logic signed [STATE_BITS-1:0] quad_upd, inph_upd, quad_load, inph_load;

   // saturate to the signed state range
   function automatic logic signed [STATE_BITS-1:0] sat_state(
      input logic signed [XW-1:0] v
   );
      logic signed [STATE_BITS-1:0] r;
      r = v[STATE_BITS-1:0];
      if (v > STMAX) begin
         r = STMAX[STATE_BITS-1:0];
      end else if (v < STMIN) begin
         r = STMIN[STATE_BITS-1:0];
      end
      return r;
   endfunction

   // start value rescale with round half up
   function automatic logic signed [XW-1:0] load_scale(
      input logic signed [CFG_BITS-1:0] c
   );
      logic signed [LW-1:0] t;
      t = ((LW'(c) + LOAD_RND) >>> LOAD_SHR) <<< LOAD_SHL;
      return XW'(t);
   endfunction

   assign req_bus.ready = (state_ff == ST_IDLE) && slot_free;
   assign accept        = req_bus.valid && req_bus.ready;
   assign restart       = accept && (req_bus.command == CMD_RESTART);
   assign sample_go     = accept && (req_bus.command != CMD_RESTART);

   always_comb begin
      quad_upd  = sat_state(XW'(quad_ff) + XW'(product));
      inph_upd  = sat_state(XW'(inph_ff) - XW'(product));
      quad_load = sat_state(load_scale(start_quad_ff));
      inph_load = sat_state(load_scale(start_inph_ff));
   end

   // sequencer: quad += eps*inph, then inph -= eps*quad with the new quad
   always_comb begin
      state_in     = state_ff;
      quad_in      = quad_ff;
      inph_in      = inph_ff;
      mult_start   = 1'b0;
      mult_operand = inph_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (restart) begin
               quad_in = quad_load;
               inph_in = inph_load;
            end else if (sample_go) begin
               mult_start = 1'b1;
               state_in   = ST_MUL_QUAD;
            end
         end
         ST_MUL_QUAD: begin
            if (mult_done) begin
               quad_in      = quad_upd;
               mult_operand = quad_upd;
               mult_start   = 1'b1;
               state_in     = ST_MUL_INPH;
            end
         end
         ST_MUL_INPH: begin
            if (mult_done) begin
               inph_in  = inph_upd;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         start_quad_ff <= START_QUAD_RESET;
         start_inph_ff <= '0;
         quad_ff       <= QUAD_RESET;
         inph_ff       <= '0;
      end else begin
         state_ff <= state_in;
         quad_ff  <= quad_in;
         inph_ff  <= inph_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_STEP_COEFFICIENT: step_ff       <= csr_write_data;
               CSR_START_QUADRATURE: start_quad_ff <= csr_write_data;
               CSR_START_INPHASE:    start_inph_ff <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

   // shared bit-serial multiplier for both half-steps
   cfso_serial_mult #(
      .STATE_BITS (STATE_BITS)
   ) u_mult (
      .clock   (clock),
      .reset   (reset),
      .start   (mult_start),
      .coef    (step_ff),
      .operand (mult_operand),
      .done    (mult_done),
      .product (product)
   );

   // result built from the in-phase state before the update
   cfso_sample_out #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .STATE_BITS  (STATE_BITS)
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (sample_go),
      .command   (req_bus.command),
      .sample_in (req_bus.sample_in),
      .inphase   (inph_ff),
      .slot_free (slot_free),
      .rsp_bus   (rsp_bus)
   );

endmodule

`default_nettype wire

>>> sim/tb_coupled_form_sine_oscillator_core.sv
// testbench of the coupled-form sine oscillator: predicted tone samples checked item by item
`timescale 1ns / 100ps

module tb_coupled_form_sine_oscillator_core;
   import cfso_pkg::*;

   localparam int SAMPLE_BITS = 24;
   localparam int STATE_BITS  = 32;
   localparam int STATE_FRAC  = STATE_BITS - 3;
   localparam int SAMPLE_FRAC = SAMPLE_BITS - 1;

   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 240;
   // long enough to cover a busy block through its serial update
   localparam int SETTLE_CYCLES   = 120;
   localparam int CYCLE_LIMIT     = 1000000;
   // long receiver hold that backs the block up into its input
   localparam int LONG_HOLD_AT     = 300;
   localparam int LONG_HOLD_CYCLES = 600;
   localparam int MAX_REPORTS      = 200;

   // index past the register list, writes there are dropped
   localparam csr_index_type CSR_SPARE = 2'd3;

   typedef logic signed [SAMPLE_BITS-1:0] sample_word;
   typedef logic signed [STATE_BITS-1:0]  state_word;

   typedef struct {
      sample_word sample;
      logic       clipped;
   } tone_result;

   localparam sample_word SAMPLE_TOP    = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam sample_word SAMPLE_BOTTOM = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam state_word  STATE_TOP     = {1'b0, {(STATE_BITS-1){1'b1}}};
   localparam state_word  STATE_BOTTOM  = {1'b1, {(STATE_BITS-1){1'b0}}};

   // tracks oscillator state and the tone samples still owed by the block
   class tone_scoreboard;
      logic [EPS_BITS-1:0] step_coef  = '0;
      state_word           start_quad = START_QUAD_RESET;
      state_word           start_inph = '0;
      state_word           quad       = START_QUAD_RESET;
      state_word           inph       = '0;
      tone_result          awaited[$];
      int                  failures   = 0;

      function void write_register(csr_index_type idx, logic [CFG_BITS-1:0] data);
         case (idx)
            CSR_STEP_COEFFICIENT: step_coef  = data;
            CSR_START_QUADRATURE: start_quad = data;
            CSR_START_INPHASE:    start_inph = data;
            default: ;
         endcase
      endfunction

      // eps * x back at state scale, round half up
      function longint scaled_product(state_word x);
         longint p;
         p = longint'({32'd0, step_coef}) * longint'(x);
         return (p + (longint'(1) <<< (EPS_FRAC - 1))) >>> EPS_FRAC;
      endfunction

      function state_word clamp_state(longint v);
         if (v > longint'(STATE_TOP))
            return STATE_TOP;
         if (v < longint'(STATE_BOTTOM))
            return STATE_BOTTOM;
         return v[STATE_BITS-1:0];
      endfunction

      function void note_request(command_type cmd, sample_word smp);
         tone_result r;
         longint     tone;
         longint     y;
         if (cmd == CMD_RESTART) begin
            // start values share the state format, no rescale needed
            quad = start_quad;
            inph = start_inph;
            return;
         end
         tone = (longint'(inph) + (longint'(1) <<< (STATE_FRAC - SAMPLE_FRAC - 1)))
                >>> (STATE_FRAC - SAMPLE_FRAC);
         y = (cmd == CMD_ADD) ? longint'(smp) + tone : tone;
         r.sample  = '0;
         r.clipped = 1'b0;
         if (cmd != CMD_BYPASS) begin
            if (y > longint'(SAMPLE_TOP)) begin
               r.sample  = SAMPLE_TOP;
               r.clipped = 1'b1;
            end else if (y < longint'(SAMPLE_BOTTOM)) begin
               r.sample  = SAMPLE_BOTTOM;
               r.clipped = 1'b1;
            end else begin
               r.sample = y[SAMPLE_BITS-1:0];
            end
         end
         awaited.push_back(r);
         // quadrature first, in-phase uses the new quadrature
         quad = clamp_state(longint'(quad) + scaled_product(inph));
         inph = clamp_state(longint'(inph) - scaled_product(quad));
      endfunction

      function void check_result(sample_word got_sample, logic got_clip);
         tone_result want;
         if (awaited.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $error("unexpected item: sample_out %0d clipped %0b", got_sample, got_clip);
            return;
         end
         want = awaited.pop_front();
         if (got_sample !== want.sample) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $error("sample_out: expected %0d, actual %0d", want.sample, got_sample);
         end
         if (got_clip !== want.clipped) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $error("clipped: expected %0b, actual %0b", want.clipped, got_clip);
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_enable;
   csr_index_type         csr_index;
   logic [CFG_BITS-1:0]   csr_write_data;
   bit                    calm = 1'b0;
   int                    cycle_count = 0;
   tone_scoreboard        board = new;

   cfso_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus ();
   cfso_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_bus ();

   coupled_form_sine_oscillator_core #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .STATE_BITS  (STATE_BITS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // result side: random stall bursts, free stretches, one long hold
   initial begin : result_sink
      int stall;
      int free_run;
      int hold;
      int taken;
      stall    = 0;
      free_run = 0;
      hold     = 0;
      taken    = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            board.check_result(rsp_bus.sample_out, rsp_bus.clipped);
            taken++;
            if (taken == LONG_HOLD_AT)
               hold = LONG_HOLD_CYCLES;
         end
         if (hold > 0) begin
            hold--;
            rsp_bus.ready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            if (stall == 0)
               free_run = $urandom_range(0, 200);
            rsp_bus.ready <= 1'b0;
         end else if (free_run > 0) begin
            free_run--;
            rsp_bus.ready <= 1'b1;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall = $urandom_range(1, 13) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // offers one item, leaves valid up so a following item goes back to back
   task automatic send_item(input command_type cmd, input sample_word smp);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.command   <= cmd;
      req_bus.sample_in <= smp;
      do
         @(posedge clock);
      while (!req_bus.ready);
      board.note_request(cmd, smp);
   endtask

   // drop valid, wait for all owed items and for the state update to finish
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CFG_BITS-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      board.write_register(idx, data);
   endtask

   task automatic program_oscillator(input logic [CFG_BITS-1:0] eps,
                                     input logic [CFG_BITS-1:0] quad_start,
                                     input logic [CFG_BITS-1:0] inph_start);
      write_csr(CSR_STEP_COEFFICIENT, eps);
      write_csr(CSR_START_QUADRATURE, quad_start);
      write_csr(CSR_START_INPHASE, inph_start);
      write_csr(CSR_SPARE, $urandom);
      csr_write_enable <= 1'b0;
   endtask

   function automatic sample_word pick_sample();
      case ($urandom_range(0, 9))
         0:       return SAMPLE_TOP;
         1:       return SAMPLE_BOTTOM;
         default: return sample_word'($urandom);
      endcase
   endfunction

   function automatic logic [CFG_BITS-1:0] pick_start();
      if ($urandom_range(0, 1) == 1)
         return $urandom;
      // within about +-1.0
      return CFG_BITS'($urandom_range(0, 32'h4000_0000)) - 32'h2000_0000;
   endfunction

   task automatic run_random_phase(input int count);
      int pick;
      send_item(CMD_RESTART, pick_sample());
      for (int n = 1; n < count; n++) begin
         pick = $urandom_range(0, 19);
         if (pick == 0)
            send_item(CMD_RESTART, pick_sample());
         else if (pick < 7)
            send_item(CMD_ADD, pick_sample());
         else if (pick < 13)
            send_item(CMD_REPLACE, pick_sample());
         else
            send_item(CMD_BYPASS, pick_sample());
      end
   endtask

   initial begin : stimulus
      logic [CFG_BITS-1:0] eps;
      logic [CFG_BITS-1:0] quad_start;
      logic [CFG_BITS-1:0] inph_start;
      reset             <= 1'b1;
      csr_write_enable  <= 1'b0;
      csr_index         <= CSR_STEP_COEFFICIENT;
      csr_write_data    <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.command   <= CMD_ADD;
      req_bus.sample_in <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: zero step, tone stays at zero
      send_item(CMD_ADD, SAMPLE_TOP);
      send_item(CMD_ADD, SAMPLE_BOTTOM);
      send_item(CMD_REPLACE, '0);
      send_item(CMD_BYPASS, sample_word'(24'h5A5A5A));
      send_item(CMD_RESTART, SAMPLE_TOP);
      settle();

      // in-phase start at +1.0, replace clips high
      program_oscillator(32'h1000_0000, START_QUAD_RESET, 32'h2000_0000);
      send_item(CMD_RESTART, '0);
      send_item(CMD_REPLACE, '0);
      send_item(CMD_ADD, SAMPLE_TOP);
      send_item(CMD_ADD, SAMPLE_BOTTOM);
      send_item(CMD_ADD, '0);
      send_item(CMD_BYPASS, SAMPLE_TOP);
      send_item(CMD_REPLACE, SAMPLE_BOTTOM);
      send_item(CMD_ADD, SAMPLE_BOTTOM);
      settle();

      // step of exactly 2.0 from -1.0: state runs into saturation
      program_oscillator(32'h8000_0000, START_QUAD_RESET, START_QUAD_RESET);
      send_item(CMD_RESTART, '0);
      send_item(CMD_REPLACE, '0);
      send_item(CMD_ADD, SAMPLE_BOTTOM);
      send_item(CMD_ADD, SAMPLE_TOP);
      send_item(CMD_BYPASS, '0);
      settle();

      // rounding ties on the way down to sample width, both signs
      program_oscillator(32'h0000_0000, 32'h0000_0020, 32'h0000_0020);
      send_item(CMD_RESTART, '0);
      send_item(CMD_REPLACE, '0);
      settle();
      program_oscillator(32'h0000_0000, 32'hFFFF_FFE0, 32'hFFFF_FFE0);
      send_item(CMD_RESTART, '0);
      send_item(CMD_REPLACE, '0);
      settle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         calm = (p == RANDOM_PHASES - 1);
         case (p)
            0: begin
               eps        = 32'h8000_0000;
               quad_start = STATE_TOP;
               inph_start = STATE_BOTTOM;
            end
            1: begin
               // step far above 2.0, used as given
               eps        = 32'hFFFF_FFFF;
               quad_start = STATE_BOTTOM;
               inph_start = STATE_TOP;
            end
            2: begin
               eps        = '0;
               quad_start = pick_start();
               inph_start = pick_start();
            end
            default: begin
               eps        = ($urandom_range(0, 2) != 0) ? CFG_BITS'($urandom_range(0, 32'h0800_0000))
                                                        : $urandom;
               quad_start = pick_start();
               inph_start = pick_start();
            end
         endcase
         program_oscillator(eps, quad_start, inph_start);
         run_random_phase(ITEMS_PER_PHASE);
         settle();
      end

      if (board.failures == 0 && board.pending() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
